### hdl/fba_pkg.sv
// ----------------------------------------------------------------------------
// fba_pkg
// Shared constants, command and status codes, and the controller state type
// of the fragment bump allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

  localparam int ENTRIES_DEF   = 64;
  localparam int ADDR_BITS_DEF = 32;
  localparam logic [15:0] THRESHOLD_RST = 16'd512;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_ALLOC   = 2'd1;
  localparam logic [1:0] CMD_RANGE   = 2'd2;
  localparam logic [1:0] CMD_RELEASE = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BADRNG  = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_GRANT,
    S_COMPACT,
    S_DONE
  } fba_state_t;

endpackage

### hdl/fragment_bump_allocator_unit.sv
// ----------------------------------------------------------------------------
// fragment_bump_allocator_unit
// First-fit bump allocator over a table of free fragments kept as a stack in
// one synchronous memory; the top of the stack is the head of the walk order.
//
//   channel | signals                                   | dir
//   in      | in_valid/in_ready, command .. least_size   | in
//   out     | out_valid/out_ready, status, address, size | out
//   cfg     | cfg_valid/cfg_ready, cfg_data (threshold)  | in
//
// Add and release go straight from idle to the result state. An alloc walks one
// entry per cycle from the top; retiring an entry below the top moves every
// entry above it down by one, one per cycle through the memory port. A new item
// is taken while a result still waits in the output register.
// Synchronous reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module fragment_bump_allocator_unit
  import fba_pkg::*;
#(
  parameter int ENTRIES   = ENTRIES_DEF,
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  command,
  input  logic [31:0] start_addr,
  input  logic [31:0] end_addr,
  input  logic [31:0] request_size,
  input  logic [31:0] least_size,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] address,
  output logic [31:0] granted_size,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_data
);

  localparam int AW = ADDR_BITS;
  localparam int XW = (AW > 32) ? AW : 32;
  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  // entry memory: {limit, bump}
  logic [2*AW-1:0] mem [ENTRIES];
  logic [2*AW-1:0] rd_data;
  logic            mem_re, mem_we;
  logic [IW-1:0]   mem_raddr, mem_waddr;
  logic [2*AW-1:0] mem_wdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data <= mem[mem_raddr];
    end
  end

  fba_state_t state, state_next;
  logic [CW-1:0] live_count, live_count_next;
  logic [15:0]   thr;
  logic [IW-1:0] ptr, ptr_next, rd_idx, rd_idx_next;
  logic          issue, issue_next, rd_valid, rd_valid_next;
  logic [1:0]    cmd_r, cmd_r_next;
  logic [31:0]   req_r, req_r_next;
  logic          best_found, best_found_next;
  logic [XW-1:0] cur_min, cur_min_next;
  logic [IW-1:0] best_idx, best_idx_next, g_idx, g_idx_next;
  logic [AW-1:0] best_bump, best_bump_next, best_limit, best_limit_next;
  logic [AW-1:0] g_bump, g_bump_next, g_limit, g_limit_next;
  logic [AW-1:0] g_size, g_size_next, g_room, g_room_next;
  logic [1:0]    res_status, res_status_next;
  logic [AW-1:0] res_addr, res_addr_next, res_size, res_size_next;
  logic          out_valid_next;
  logic [1:0]    status_next;
  logic [31:0]   address_next, granted_size_next;

  logic [AW-1:0] e_bump, e_limit, e_room, a_start, a_end, new_bump, rem;
  logic [IW-1:0] last_idx;
  logic          hit, fallback_ok;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign e_bump    = rd_data[AW-1:0];
  assign e_limit   = rd_data[2*AW-1:AW];
  assign e_room    = e_limit - e_bump;
  assign a_start   = AW'(start_addr);
  assign a_end     = AW'(end_addr);
  assign new_bump  = g_bump + g_size;
  assign rem       = g_room - g_size;
  assign last_idx  = IW'(live_count - CW'(1));
  assign hit       = XW'(req_r) <= XW'(e_room);
  assign fallback_ok = cur_min <= XW'(e_room);

  always_comb begin
    state_next      = state;
    live_count_next = live_count;
    ptr_next        = ptr;
    rd_idx_next     = rd_idx;
    issue_next      = issue;
    rd_valid_next   = 1'b0;
    cmd_r_next      = cmd_r;
    req_r_next      = req_r;
    best_found_next = best_found;
    cur_min_next    = cur_min;
    best_idx_next   = best_idx;
    best_bump_next  = best_bump;
    best_limit_next = best_limit;
    g_idx_next      = g_idx;
    g_bump_next     = g_bump;
    g_limit_next    = g_limit;
    g_size_next     = g_size;
    g_room_next     = g_room;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    res_size_next   = res_size;
    out_valid_next  = out_valid & ~out_ready;
    status_next       = status;
    address_next      = address;
    granted_size_next = granted_size;
    mem_re    = 1'b0;
    mem_raddr = ptr;
    mem_we    = 1'b0;
    mem_waddr = g_idx;
    mem_wdata = {g_limit, new_bump};

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd_r_next      = command;
          req_r_next      = request_size;
          cur_min_next    = XW'(least_size);
          best_found_next = 1'b0;
          res_status_next = ST_OK;
          res_addr_next   = '0;
          res_size_next   = '0;
          state_next      = S_DONE;
          case (command)
            CMD_ADD: begin
              if (a_end <= a_start) begin
                res_status_next = ST_BADRNG;
              end else if (live_count >= CW'(ENTRIES)) begin
                res_status_next = ST_FULL;
              end else begin
                mem_we          = 1'b1;
                mem_waddr       = IW'(live_count);
                mem_wdata       = {a_end, a_start};
                live_count_next = live_count + CW'(1);
                res_addr_next   = a_start;
                res_size_next   = a_end - a_start;
              end
            end
            CMD_RELEASE: begin
              live_count_next = '0;
            end
            default: begin
              if (live_count == '0) begin
                res_status_next = ST_NOFIT;
              end else begin
                ptr_next   = last_idx;
                issue_next = 1'b1;
                state_next = S_WALK;
              end
            end
          endcase
        end
      end

      S_WALK: begin
        // issue reads from the top down; evaluate the previous read
        if (issue) begin
          mem_re        = 1'b1;
          rd_valid_next = 1'b1;
          rd_idx_next   = ptr;
          if (ptr == '0) begin
            issue_next = 1'b0;
          end else begin
            ptr_next = ptr - IW'(1);
          end
        end
        if (rd_valid) begin
          if (hit) begin
            g_idx_next    = rd_idx;
            g_bump_next   = e_bump;
            g_limit_next  = e_limit;
            g_room_next   = e_room;
            g_size_next   = AW'(req_r);
            issue_next    = 1'b0;
            rd_valid_next = 1'b0;
            state_next    = S_GRANT;
          end else begin
            if (cmd_r == CMD_RANGE && fallback_ok) begin
              best_found_next = 1'b1;
              cur_min_next    = XW'(e_room);
              best_idx_next   = rd_idx;
              best_bump_next  = e_bump;
              best_limit_next = e_limit;
            end
            if (rd_idx == '0) begin
              issue_next    = 1'b0;
              rd_valid_next = 1'b0;
              if (cmd_r == CMD_RANGE && (fallback_ok || best_found)) begin
                g_idx_next   = fallback_ok ? rd_idx : best_idx;
                g_bump_next  = fallback_ok ? e_bump : best_bump;
                g_limit_next = fallback_ok ? e_limit : best_limit;
                g_room_next  = fallback_ok ? e_room : AW'(cur_min);
                g_size_next  = fallback_ok ? e_room : AW'(cur_min);
                state_next   = S_GRANT;
              end else begin
                res_status_next = ST_NOFIT;
                state_next      = S_DONE;
              end
            end
          end
        end
      end

      S_GRANT: begin
        res_status_next = ST_OK;
        res_addr_next   = g_bump;
        res_size_next   = g_size;
        if (XW'(rem) < XW'(thr)) begin
          // retire: drop the top, or pull the entries above down by one
          if (g_idx == last_idx) begin
            live_count_next = live_count - CW'(1);
            state_next      = S_DONE;
          end else begin
            ptr_next   = g_idx + IW'(1);
            issue_next = 1'b1;
            state_next = S_COMPACT;
          end
        end else begin
          mem_we     = 1'b1;
          state_next = S_DONE;
        end
      end

      S_COMPACT: begin
        if (issue) begin
          mem_re        = 1'b1;
          rd_valid_next = 1'b1;
          rd_idx_next   = ptr;
          if (ptr == last_idx) begin
            issue_next = 1'b0;
          end else begin
            ptr_next = ptr + IW'(1);
          end
        end
        if (rd_valid) begin
          mem_we    = 1'b1;
          mem_waddr = rd_idx - IW'(1);
          mem_wdata = rd_data;
          if (rd_idx == last_idx) begin
            live_count_next = live_count - CW'(1);
            state_next      = S_DONE;
          end
        end
      end

      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next    = 1'b1;
          status_next       = res_status;
          address_next      = (res_status == ST_OK) ? 32'(res_addr) : '0;
          granted_size_next = (res_status == ST_OK) ? 32'(res_size) : '0;
          state_next        = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      live_count <= '0;
      thr        <= THRESHOLD_RST;
      issue      <= 1'b0;
      rd_valid   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state      <= state_next;
      live_count <= live_count_next;
      issue      <= issue_next;
      rd_valid   <= rd_valid_next;
      out_valid  <= out_valid_next;
      if (cfg_valid) begin
        thr <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ptr          <= ptr_next;
    rd_idx       <= rd_idx_next;
    cmd_r        <= cmd_r_next;
    req_r        <= req_r_next;
    best_found   <= best_found_next;
    cur_min      <= cur_min_next;
    best_idx     <= best_idx_next;
    best_bump    <= best_bump_next;
    best_limit   <= best_limit_next;
    g_idx        <= g_idx_next;
    g_bump       <= g_bump_next;
    g_limit      <= g_limit_next;
    g_size       <= g_size_next;
    g_room       <= g_room_next;
    res_status   <= res_status_next;
    res_addr     <= res_addr_next;
    res_size     <= res_size_next;
    status       <= status_next;
    address      <= address_next;
    granted_size <= granted_size_next;
  end

  a_live_bound: assert property (@(posedge clk) disable iff (rst)
    live_count <= CW'(ENTRIES))
    else $error("live count beyond table size");

  a_release_empties: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && command == CMD_RELEASE) |=> live_count == '0)
    else $error("release left entries");

  a_compact_not_bottom: assert property (@(posedge clk) disable iff (rst)
    (state == S_COMPACT && rd_valid) |-> rd_idx != '0)
    else $error("compaction read at bottom slot");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> live_count != '0)
    else $error("walk on empty table");

endmodule
